@@ hw/rtl/stepper_move_sequencer_top_macros.svh @@
// ----------------------------------------------------------------------------
// Stepper move sequencer assertion macros
// Shared concurrent assertion forms; define NO_ASSERTIONS to drop them.
// ----------------------------------------------------------------------------
`ifndef STEPPER_MOVE_SEQUENCER_TOP_MACROS_SVH
`define STEPPER_MOVE_SEQUENCER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is asserted
`define SMS_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define SMS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define SMS_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define SMS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

@@ hw/rtl/smseq_pkg.sv @@
// ----------------------------------------------------------------------------
// Stepper move sequencer package
// Request codes, payload types, timing widths and the full-step coil table.
// ----------------------------------------------------------------------------
package smseq_pkg;

    // Width of the saturating elapsed-time counter (8 to 64)
    localparam int TIME_WIDTH = 32;
    localparam int INTERVAL_WIDTH = 32;
    localparam int STEPS_WIDTH = 16;
    localparam int PHASE_WIDTH = 2;
    localparam int COIL_WIDTH = 4;
    // Width used for the elapsed-versus-interval compare
    localparam int CMP_WIDTH = (TIME_WIDTH > INTERVAL_WIDTH) ? TIME_WIDTH : INTERVAL_WIDTH;

    typedef enum logic [1:0] {
        REQ_TICK     = 2'd0,
        REQ_SET_MOVE = 2'd1,
        REQ_CANCEL   = 2'd2,
        REQ_DISABLE  = 2'd3
    } req_type_t;

    typedef struct packed {
        req_type_t                      req_type;
        logic signed [STEPS_WIDTH-1:0]  move_steps;
        logic [INTERVAL_WIDTH-1:0]      step_interval;
    } smseq_in_t;

    typedef struct packed {
        logic [COIL_WIDTH-1:0]          coil_pattern;
        logic signed [STEPS_WIDTH-1:0]  steps_remaining;
        logic                           move_accepted;
        logic                           stepped;
    } smseq_out_t;

    // Full-step sequence, bit 3 drives coil C0
    function automatic logic [COIL_WIDTH-1:0] coil_lookup(input logic [PHASE_WIDTH-1:0] ph);
        logic [COIL_WIDTH-1:0] pat;
        case (ph)
            2'd0:    pat = 4'b1010;
            2'd1:    pat = 4'b0110;
            2'd2:    pat = 4'b0101;
            2'd3:    pat = 4'b1001;
            default: pat = 4'b0000;
        endcase
        return pat;
    endfunction

endpackage

@@ hw/rtl/smseq_in_stage.sv @@
// ----------------------------------------------------------------------------
// Stepper move sequencer input stage
// Registers one request and offers it to the core; refills in the cycle it drains.
// ----------------------------------------------------------------------------
module smseq_in_stage
    import smseq_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  smseq_in_t  s_payload,
    input  logic       drain,
    output logic       in_valid,
    output smseq_in_t  in_data
);

    logic      in_valid_reg;
    logic      in_valid_next;
    smseq_in_t in_data_reg;

    // Accept when empty or when the held request moves on this cycle
    assign s_ready = !in_valid_reg || drain;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (drain) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    // Hold the payload of the pending transfer
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_payload;
        end
    end

    assign in_valid = in_valid_reg;
    assign in_data  = in_data_reg;

endmodule

@@ hw/rtl/smseq_core.sv @@
// ----------------------------------------------------------------------------
// Stepper move sequencer core
// Holds phase, coil enable, step count, interval and elapsed time; updates
// them for one request per cycle while fire is high, and forms the result.
// ----------------------------------------------------------------------------
`include "stepper_move_sequencer_top_macros.svh"

module smseq_core
    import smseq_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       fire,
    input  smseq_in_t  req,
    output smseq_out_t result
);

    logic [PHASE_WIDTH-1:0]          phase_reg, phase_next;
    logic                            coils_en_reg, coils_en_next;
    logic signed [STEPS_WIDTH-1:0]   steps_left_reg, steps_left_next;
    logic [INTERVAL_WIDTH-1:0]       interval_reg, interval_next;
    logic [TIME_WIDTH-1:0]           elapsed_reg, elapsed_next;

    logic [TIME_WIDTH-1:0]           elapsed_inc;
    logic                            step_due;
    logic                            accepted;
    logic                            stepped;

    // Saturating increment of elapsed time
    assign elapsed_inc = (&elapsed_reg) ? elapsed_reg : elapsed_reg + TIME_WIDTH'(1);

    // Step when steps remain and the interval has run out
    assign step_due = (steps_left_reg != '0) &&
                      (CMP_WIDTH'(elapsed_inc) >= CMP_WIDTH'(interval_reg));

    // Next state for the request in the input stage
    always_comb begin
        phase_next      = phase_reg;
        coils_en_next   = coils_en_reg;
        steps_left_next = steps_left_reg;
        interval_next   = interval_reg;
        elapsed_next    = elapsed_reg;
        accepted        = 1'b0;
        stepped         = 1'b0;
        case (req.req_type)
            REQ_TICK: begin
                elapsed_next = elapsed_inc;
                if (step_due) begin
                    if (steps_left_reg[STEPS_WIDTH-1]) begin
                        phase_next      = phase_reg - PHASE_WIDTH'(1);
                        steps_left_next = steps_left_reg + STEPS_WIDTH'(1);
                    end else begin
                        phase_next      = phase_reg + PHASE_WIDTH'(1);
                        steps_left_next = steps_left_reg - STEPS_WIDTH'(1);
                    end
                    coils_en_next = 1'b1;
                    elapsed_next  = '0;
                    stepped       = 1'b1;
                end
            end
            REQ_SET_MOVE: begin
                interval_next = req.step_interval;
                if (steps_left_reg == '0) begin
                    steps_left_next = req.move_steps;
                    accepted        = 1'b1;
                end
            end
            REQ_CANCEL: begin
                steps_left_next = '0;
            end
            REQ_DISABLE: begin
                coils_en_next = 1'b0;
            end
            default: begin
                coils_en_next = coils_en_reg;
            end
        endcase
    end

    // Commit state only when the request moves to the result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= '0;
            coils_en_reg   <= 1'b0;
            steps_left_reg <= '0;
            interval_reg   <= '0;
            elapsed_reg    <= '0;
        end else if (fire) begin
            phase_reg      <= phase_next;
            coils_en_reg   <= coils_en_next;
            steps_left_reg <= steps_left_next;
            interval_reg   <= interval_next;
            elapsed_reg    <= elapsed_next;
        end
    end

    // Result reflects the state after this request
    assign result.coil_pattern    = coils_en_next ? coil_lookup(phase_next) : '0;
    assign result.steps_remaining = steps_left_next;
    assign result.move_accepted   = accepted;
    assign result.stepped         = stepped;

    `SMS_ASSERT_NEXT(a_step_clears_elapsed, aclk, aresetn, fire && stepped, elapsed_reg == '0)
    `SMS_ASSERT_NEXT(a_step_enables_coils, aclk, aresetn, fire && stepped, coils_en_reg)
    `SMS_ASSERT_NEXT(a_cancel_clears_steps, aclk, aresetn, fire && req.req_type == REQ_CANCEL, steps_left_reg == '0)
    `SMS_ASSERT_NEXT(a_idle_holds_phase, aclk, aresetn, !fire, $stable(phase_reg) && $stable(steps_left_reg))

endmodule

@@ hw/rtl/smseq_out_stage.sv @@
// ----------------------------------------------------------------------------
// Stepper move sequencer output stage
// Result register toward the downstream channel.
// ----------------------------------------------------------------------------
module smseq_out_stage
    import smseq_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       load,
    input  smseq_out_t result,
    output logic       space,
    output logic       m_valid,
    input  logic       m_ready,
    output smseq_out_t m_payload
);

    logic       out_valid_reg;
    logic       out_valid_next;
    smseq_out_t out_data_reg;

    // Room for a new result when empty or when the held one transfers now
    assign space = !out_valid_reg || m_ready;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_data_reg <= result;
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_payload = out_data_reg;

endmodule

@@ hw/rtl/stepper_move_sequencer_top.sv @@
// ----------------------------------------------------------------------------
// Stepper move sequencer top level
// Four-coil full-step driver: ticks, move requests, cancel and disable in,
// one coil/status result out per request.
// ----------------------------------------------------------------------------
//   channel   | direction | handshake          | payload
//   ----------+-----------+--------------------+-------------------------------
//   request   | in        | s_valid / s_ready  | s_payload (smseq_in_t)
//   result    | out       | m_valid / m_ready  | m_payload (smseq_out_t)
//
// One request per cycle sustained while m_ready stays high; a request passes
// through the input register and then the result register before its result appears.
// aresetn is synchronous: phase, step count, interval and elapsed clear to zero,
// coils off, both stages empty.
// A stalled result holds the result register and, one request later, the
// input register; s_ready then drops until m_ready returns.
// ----------------------------------------------------------------------------
module stepper_move_sequencer_top
    import smseq_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  smseq_in_t  s_payload,
    output logic       m_valid,
    input  logic       m_ready,
    output smseq_out_t m_payload
);

    logic       in_valid;
    smseq_in_t  in_data;
    logic       space;
    logic       fire;
    smseq_out_t result;

    // Advance a request when the result register has room
    assign fire = in_valid && space;

    smseq_in_stage u_in_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .drain     (fire),
        .in_valid  (in_valid),
        .in_data   (in_data)
    );

    smseq_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .req     (in_data),
        .result  (result)
    );

    smseq_out_stage u_out_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (fire),
        .result    (result),
        .space     (space),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule

@@ test/stepper_move_sequencer_top_tb.sv @@
// ----------------------------------------------------------------------------
// Stepper move sequencer testbench
// Drives tick, move, cancel and disable requests through the request channel
// with random gaps and stalls on both sides. A local model of the phase,
// step count, interval and elapsed counter predicts every result, and each
// result transfer is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stepper_move_sequencer_top_tb;
    import smseq_pkg::*;

    localparam int STALL_LIMIT = 2000;  // cycles without any transfer
    localparam int HOLD_CYCLES = 200;   // long receiver hold-off
    localparam int SETTLE_CYCLES = 8;   // extra wait after the last result

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    smseq_in_t  s_payload = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    smseq_out_t m_payload;

    // Motor model state
    logic [PHASE_WIDTH-1:0]        mtr_phase = '0;
    logic                          mtr_coils_on = 1'b0;
    logic signed [STEPS_WIDTH-1:0] mtr_steps_left = '0;
    logic [INTERVAL_WIDTH-1:0]     mtr_interval = '0;
    logic [TIME_WIDTH-1:0]         mtr_elapsed = '0;

    logic [COIL_WIDTH-1:0] full_step_coils [4] = '{4'b1010, 4'b0110, 4'b0101, 4'b1001};

    smseq_out_t expected_results [$];
    int         mismatch_count = 0;
    int         quiet_cycles = 0;
    int         src_idle_pct = 0;
    int         sink_idle_pct = 0;
    int         sink_hold_left = 0;

    stepper_move_sequencer_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Advance the motor model by one request and return its result
    function automatic smseq_out_t predict_result(input smseq_in_t req);
        smseq_out_t res;
        logic [CMP_WIDTH-1:0] elapsed_w;
        logic [CMP_WIDTH-1:0] interval_w;
        res = '0;
        case (req.req_type)
            REQ_TICK: begin
                if (mtr_elapsed != '1)
                    mtr_elapsed = mtr_elapsed + TIME_WIDTH'(1);
                elapsed_w = CMP_WIDTH'(mtr_elapsed);
                interval_w = CMP_WIDTH'(mtr_interval);
                if (mtr_steps_left != 0 && elapsed_w >= interval_w) begin
                    if (mtr_steps_left > 0) begin
                        mtr_phase = mtr_phase + PHASE_WIDTH'(1);
                        mtr_steps_left = mtr_steps_left - 16'sd1;
                    end else begin
                        mtr_phase = mtr_phase - PHASE_WIDTH'(1);
                        mtr_steps_left = mtr_steps_left + 16'sd1;
                    end
                    mtr_coils_on = 1'b1;
                    mtr_elapsed = '0;
                    res.stepped = 1'b1;
                end
            end
            REQ_SET_MOVE: begin
                mtr_interval = req.step_interval;
                if (mtr_steps_left == 0) begin
                    mtr_steps_left = req.move_steps;
                    res.move_accepted = 1'b1;
                end
            end
            REQ_CANCEL: mtr_steps_left = '0;
            default:    mtr_coils_on = 1'b0;
        endcase
        res.coil_pattern = mtr_coils_on ? full_step_coils[mtr_phase] : '0;
        res.steps_remaining = mtr_steps_left;
        return res;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] exp_val,
                                   input logic [31:0] act_val);
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_val, act_val);
        mismatch_count++;
    endtask

    // Predict on each request transfer, check each result transfer, watch for stalls
    always @(posedge aclk) begin
        smseq_out_t exp_res;
        if (aresetn) begin
            if (s_valid && s_ready)
                expected_results.push_back(predict_result(s_payload));
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result transfer with nothing expected, actual %h",
                             $time, m_payload);
                    mismatch_count++;
                end else begin
                    exp_res = expected_results.pop_front();
                    if (m_payload.coil_pattern !== exp_res.coil_pattern)
                        report_mismatch("coil_pattern", 32'(exp_res.coil_pattern),
                                        32'(m_payload.coil_pattern));
                    if (m_payload.steps_remaining !== exp_res.steps_remaining)
                        report_mismatch("steps_remaining", 32'(exp_res.steps_remaining),
                                        32'(m_payload.steps_remaining));
                    if (m_payload.move_accepted !== exp_res.move_accepted)
                        report_mismatch("move_accepted", 32'(exp_res.move_accepted),
                                        32'(m_payload.move_accepted));
                    if (m_payload.stepped !== exp_res.stepped)
                        report_mismatch("stepped", 32'(exp_res.stepped),
                                        32'(m_payload.stepped));
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Drive the receiver: random stalls, or a counted hold-off when requested
    always @(negedge aclk) begin
        if (sink_hold_left > 0) begin
            m_ready <= 1'b0;
            sink_hold_left--;
        end else begin
            m_ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    function automatic smseq_in_t request_of(input req_type_t kind, input int steps,
                                             input logic [31:0] interval);
        smseq_in_t req;
        req.req_type = kind;
        req.move_steps = 16'(steps);
        req.step_interval = interval;
        return req;
    endfunction

    // Offer one request after a random gap and hold it until it transfers
    task automatic send_request(input smseq_in_t req);
        while ($urandom_range(99) < src_idle_pct) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_payload <= req;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Drop valid and wait for every outstanding result
    task automatic wait_results_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Random ticks with junk in the unused fields
    function automatic smseq_in_t random_tick();
        return request_of(REQ_TICK, int'($urandom), $urandom);
    endfunction

    // Move requests followed by runs of ticks, with cancel, disable and
    // stray move requests mixed in
    task automatic run_random_moves(input int n_items);
        int sent;
        int pick;
        bit wide_move;
        smseq_in_t req;
        sent = 0;
        while (sent < n_items) begin
            wide_move = ($urandom_range(9) == 0);
            if (wide_move)
                req = request_of(REQ_SET_MOVE, int'($urandom), $urandom);
            else
                req = request_of(REQ_SET_MOVE, int'($urandom_range(16)) - 8,
                                 $urandom_range(4));
            send_request(req);
            sent++;
            repeat ($urandom_range(1, 20)) begin
                pick = $urandom_range(99);
                if (pick < 85)
                    req = random_tick();
                else if (pick < 90)
                    req = request_of(REQ_CANCEL, int'($urandom), $urandom);
                else if (pick < 95)
                    req = request_of(REQ_DISABLE, int'($urandom), $urandom);
                else
                    req = request_of(REQ_SET_MOVE, int'($urandom_range(16)) - 8,
                                     $urandom_range(3));
                send_request(req);
                sent++;
            end
            // Clear long moves so later requests load again
            if (wide_move || $urandom_range(3) == 0) begin
                send_request(request_of(REQ_CANCEL, 0, 0));
                sent++;
            end
        end
    endtask

    task automatic test_directed_cases();
        src_idle_pct = 0;
        sink_idle_pct = 0;
        // Requests on an idle motor with coils off
        send_request(request_of(REQ_TICK, 0, 0));
        send_request(request_of(REQ_DISABLE, 0, 0));
        send_request(request_of(REQ_CANCEL, 0, 0));
        // Zero count loads but nothing moves
        send_request(request_of(REQ_SET_MOVE, 0, 0));
        send_request(request_of(REQ_TICK, 0, 0));
        // Zero interval: one step per tick, forward through phases 1 to 3
        send_request(request_of(REQ_SET_MOVE, 3, 0));
        repeat (4) send_request(request_of(REQ_TICK, 0, 0));
        // Forward wrap from phase 3 to 0, then backward wrap from 0 to 3
        send_request(request_of(REQ_SET_MOVE, 1, 0));
        send_request(request_of(REQ_TICK, 0, 0));
        send_request(request_of(REQ_SET_MOVE, -2, 0));
        repeat (2) send_request(request_of(REQ_TICK, 0, 0));
        // Move request while a move runs: count ignored, interval stored
        send_request(request_of(REQ_SET_MOVE, 4, 2));
        send_request(request_of(REQ_SET_MOVE, 100, 1));
        repeat (2) send_request(request_of(REQ_TICK, 0, 0));
        // Disable, then the next step turns the coils back on
        send_request(request_of(REQ_DISABLE, 0, 0));
        send_request(request_of(REQ_TICK, 0, 0));
        send_request(request_of(REQ_CANCEL, 0, 0));
        // Extreme counts and interval
        send_request(request_of(REQ_SET_MOVE, 32767, 32'hFFFF_FFFF));
        send_request(request_of(REQ_TICK, -1, 32'hFFFF_FFFF));
        send_request(request_of(REQ_CANCEL, -1, 32'hFFFF_FFFF));
        send_request(request_of(REQ_SET_MOVE, -32768, 32'hFFFF_FFFF));
        send_request(request_of(REQ_CANCEL, 0, 0));
        // Elapsed keeps counting between moves, so the first step comes at once
        repeat (3) send_request(request_of(REQ_TICK, 0, 0));
        send_request(request_of(REQ_SET_MOVE, 2, 3));
        repeat (2) send_request(request_of(REQ_TICK, 0, 0));
        wait_results_drained();
    endtask

    task automatic test_sender_gaps();
        src_idle_pct = 30;
        sink_idle_pct = 47;
        run_random_moves(380);
        wait_results_drained();
    endtask

    task automatic test_receiver_gaps();
        src_idle_pct = 47;
        sink_idle_pct = 30;
        run_random_moves(380);
        wait_results_drained();
    endtask

    // Hold the receiver off while requests keep coming, so the input stalls
    task automatic test_backpressure_fill();
        src_idle_pct = 0;
        sink_idle_pct = 0;
        @(posedge aclk);
        sink_hold_left = HOLD_CYCLES;
        send_request(request_of(REQ_SET_MOVE, 5, 1));
        repeat (19) send_request(random_tick());
        wait_results_drained();
    endtask

    // Pause the sender until all results are back, then resume
    task automatic test_drain_pause();
        src_idle_pct = 0;
        sink_idle_pct = 0;
        run_random_moves(10);
        wait_results_drained();
        run_random_moves(10);
        wait_results_drained();
    endtask

    task automatic test_full_rate();
        src_idle_pct = 0;
        sink_idle_pct = 0;
        run_random_moves(320);
        wait_results_drained();
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed_cases();
        test_sender_gaps();
        test_receiver_gaps();
        test_backpressure_fill();
        test_drain_pause();
        test_full_rate();
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
